// ===== hdl/cklx_pkg.sv =====
// Types, character constants and helper functions for the configuration lexer.
package cklx_pkg;

    // Parse phase; the two low bits double as the token kind of the result.
    typedef enum logic [1:0] {
        PH_HEAD  = 2'd0,
        PH_TAIL  = 2'd1,
        PH_VALUE = 2'd2,
        PH_EQ    = 2'd3
    } phase_t;

    // Closer awaited inside a shielded block or a comment.
    typedef enum logic [2:0] {
        CL_NONE    = 3'd0,
        CL_QUOTE   = 3'd1,
        CL_PAREN   = 3'd2,
        CL_BRACE   = 3'd3,
        CL_BRACKET = 3'd4,
        CL_ANGLE   = 3'd5,
        CL_LINE    = 3'd6
    } closer_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_DOT_START  = 3'd1,
        ERR_EQ_NO_KEY  = 3'd2,
        ERR_EMPTY_TAIL = 3'd3,
        ERR_NO_EQUALS  = 3'd4,
        ERR_EQ_IN_VAL  = 3'd5,
        ERR_UNFINISHED = 3'd6
    } err_t;

    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_LANGLE  = 8'h3C;
    localparam logic [7:0] CH_RANGLE  = 8'h3E;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_VT      = 8'h0B;
    localparam logic [7:0] CH_NUL     = 8'h00;

    typedef struct packed {
        phase_t  phase;
        logic    token_open;
        closer_t closer;
        logic    err_latched;
    } lex_state_t;

    typedef struct packed {
        logic       content_valid;
        logic [7:0] content_char;
        logic [1:0] token_kind;
        logic       token_end;
        logic       record_done;
        err_t       error_code;
        logic       buffer_ok;
    } lex_result_t;

    localparam lex_state_t LEX_RESET = '{
        phase:       PH_HEAD,
        token_open:  1'b0,
        closer:      CL_NONE,
        err_latched: 1'b0
    };

    // Character that ends a block; zero where no block is open.
    function automatic logic [7:0] closer_char(input closer_t cl);
        logic [7:0] ch;
        case (cl)
            CL_QUOTE:   ch = CH_QUOTE;
            CL_PAREN:   ch = CH_RPAREN;
            CL_BRACE:   ch = CH_RBRACE;
            CL_BRACKET: ch = CH_RBRACK;
            CL_ANGLE:   ch = CH_RANGLE;
            CL_LINE:    ch = CH_NEWLINE;
            default:    ch = CH_NUL;
        endcase
        return ch;
    endfunction

    function automatic closer_t opener_code(input logic [7:0] c);
        closer_t cl;
        case (c)
            CH_QUOTE:  cl = CL_QUOTE;
            CH_LPAREN: cl = CL_PAREN;
            CH_LBRACE: cl = CL_BRACE;
            CH_LBRACK: cl = CL_BRACKET;
            CH_LANGLE: cl = CL_ANGLE;
            default:   cl = CL_NONE;
        endcase
        return cl;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {CH_SPACE, CH_FF, CH_NEWLINE, CH_CR, CH_TAB, CH_VT};
    endfunction

endpackage

// ===== hdl/config_key_value_lexer_top.sv =====
// Top level of the configuration key/value lexer: input register, lexer state and result register.
//
//  Channel | Handshake           | Payload
//  --------+---------------------+---------------------------------------------
//  input   | in_valid, in_ready  | char_byte, is_last
//  output  | out_valid, out_ready| content_valid, content_char, token_kind,
//          |                     | token_end, record_done, error_code, buffer_ok
//
// One word per clock cycle sustained while out_ready holds; a word is captured in the input
// register and its result then in the result register, the state update being a single step of logic
// between the input and result registers. Reset clears the lexer state and both valid
// flags. When the result register is full and not taken, the input register holds its
// word and in_ready falls once that register is occupied.
module config_key_value_lexer_top
    import cklx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_byte,
    input  logic       is_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       content_valid,
    output logic [7:0] content_char,
    output logic [1:0] token_kind,
    output logic       token_end,
    output logic       record_done,
    output logic [2:0] error_code,
    output logic       buffer_ok
);

    logic        in_valid_reg;
    logic [7:0]  char_reg;
    logic        last_reg;
    lex_state_t  state_reg;
    lex_state_t  state_next;
    lex_result_t result_next;
    lex_result_t result_reg;
    logic        out_valid_reg;
    logic        advance;
    logic        in_accept;
    logic        process;

    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || advance;
    assign in_accept = in_valid && in_ready;
    assign process   = in_valid_reg && advance;

    cklx_step u_step (
        .state      (state_reg),
        .char_byte  (char_reg),
        .is_last    (last_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= LEX_RESET;
        end
        else
        begin
            if (in_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (process)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            char_reg <= char_byte;
            last_reg <= is_last;
        end
        if (process)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign content_valid = result_reg.content_valid;
    assign content_char  = result_reg.content_char;
    assign token_kind    = result_reg.token_kind;
    assign token_end     = result_reg.token_end;
    assign record_done   = result_reg.record_done;
    assign error_code    = result_reg.error_code;
    assign buffer_ok     = result_reg.buffer_ok;

    // A word that reports a syntax error carries no token tags.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != ERR_NONE && error_code != ERR_UNFINISHED
        |-> !content_valid && !token_end && !record_done)
        else $error("error word carries token tags");

    // A clean buffer never reports an error on the same word.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && buffer_ok |-> error_code == ERR_NONE)
        else $error("buffer_ok with an error code");

    // A completed record always closes a value token.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_done |-> token_end && token_kind == PH_VALUE)
        else $error("record_done without a value token end");

    // After the last byte is processed the lexer state is back at reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        process && last_reg |=> state_reg == LEX_RESET)
        else $error("lexer state not reset after the last byte");

endmodule

// ===== hdl/cklx_step.sv =====
// Combinational lexer step: one byte and the current state give the result and next state.
module cklx_step
    import cklx_pkg::*;
(
    input  lex_state_t  state,
    input  logic [7:0]  char_byte,
    input  logic        is_last,
    output lex_state_t  state_next,
    output lex_result_t result
);

    logic       cv;
    logic [1:0] kind;
    logic       tend;
    logic       rdone;
    err_t       err;
    logic       ok;
    closer_t    op;
    lex_state_t st;

    always_comb
    begin
        st    = state;
        cv    = 1'b0;
        kind  = 2'd0;
        tend  = 1'b0;
        rdone = 1'b0;
        err   = ERR_NONE;
        ok    = 1'b0;
        op    = opener_code(char_byte);

        if (!state.err_latched)
        begin
            if (closer_char(state.closer) != CH_NUL)
            begin
                // Inside a shielded block or a comment: everything is plain text.
                if (char_byte == closer_char(state.closer))
                begin
                    st.closer = CL_NONE;
                end
                if (state.token_open)
                begin
                    cv   = 1'b1;
                    kind = state.phase;
                end
            end
            else if (state.phase == PH_EQ)
            begin
                st.closer = CL_NONE;
                if (char_byte == CH_EQUALS)
                begin
                    st.phase = PH_VALUE;
                end
                else if (char_byte == CH_HASH)
                begin
                    st.closer = CL_LINE;
                end
                else if (!is_space(char_byte))
                begin
                    err = ERR_NO_EQUALS;
                end
            end
            else
            begin
                st.closer = CL_NONE;
                kind      = state.phase;
                if (char_byte == CH_DOT && state.phase == PH_HEAD)
                begin
                    if (!state.token_open)
                    begin
                        err = ERR_DOT_START;
                    end
                    else
                    begin
                        tend          = 1'b1;
                        st.token_open = 1'b0;
                        st.phase      = PH_TAIL;
                    end
                end
                else if (char_byte == CH_EQUALS)
                begin
                    if (state.phase == PH_VALUE)
                    begin
                        err = ERR_EQ_IN_VAL;
                    end
                    else if (!state.token_open)
                    begin
                        if (state.phase == PH_HEAD)
                        begin
                            err = ERR_EQ_NO_KEY;
                        end
                        else
                        begin
                            err = ERR_EMPTY_TAIL;
                        end
                    end
                    else
                    begin
                        tend          = 1'b1;
                        st.token_open = 1'b0;
                        st.phase      = PH_VALUE;
                    end
                end
                else if (op != CL_NONE)
                begin
                    st.token_open = 1'b1;
                    st.closer     = op;
                    cv            = 1'b1;
                end
                else if (char_byte == CH_HASH || is_space(char_byte))
                begin
                    if (state.token_open)
                    begin
                        tend          = 1'b1;
                        st.token_open = 1'b0;
                        if (state.phase == PH_VALUE)
                        begin
                            rdone    = 1'b1;
                            st.phase = PH_HEAD;
                        end
                        else
                        begin
                            st.phase = PH_EQ;
                        end
                    end
                    if (char_byte == CH_HASH)
                    begin
                        st.closer = CL_LINE;
                    end
                end
                else
                begin
                    st.token_open = 1'b1;
                    cv            = 1'b1;
                end
                if (!cv && !tend)
                begin
                    kind = 2'd0;
                end
            end

            if (err != ERR_NONE)
            begin
                st.err_latched = 1'b1;
                cv    = 1'b0;
                kind  = 2'd0;
                tend  = 1'b0;
                rdone = 1'b0;
            end
            else if (is_last)
            begin
                if (st.phase != PH_HEAD || st.token_open)
                begin
                    err = ERR_UNFINISHED;
                end
                else
                begin
                    ok = 1'b1;
                end
            end
        end

        // The lexer starts afresh after the final byte of a buffer.
        state_next = is_last ? LEX_RESET : st;

        result.content_valid = cv;
        result.content_char  = cv ? char_byte : CH_NUL;
        result.token_kind    = kind;
        result.token_end     = tend;
        result.record_done   = rdone;
        result.error_code    = err;
        result.buffer_ok     = ok;
    end

endmodule
